// File: rtl/gcer_pkg.sv
`timescale 1ns / 1ps

package gcer_pkg;

  // Default screen geometry.
  localparam int SCREEN_WIDTH_DEF   = 320;
  localparam int SCREEN_HEIGHT_DEF  = 192;
  localparam int BYTES_PER_LINE_DEF = 160;

  // Fixed field widths.
  localparam int OFF_W   = 15;
  localparam int COLOR_W = 4;
  localparam int SPACE_W = 6;

  // Operation codes carried by the op field.
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_HEADER = 2'd1;
  localparam logic [1:0] OP_BYTE   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_FG      = 2'd0;
  localparam logic [1:0] REG_BG      = 2'd1;
  localparam logic [1:0] REG_SPACING = 2'd2;

  // Nibble write masks.
  localparam logic [1:0] MASK_LO   = 2'b01;
  localparam logic [1:0] MASK_HI   = 2'b10;
  localparam logic [1:0] MASK_BOTH = 2'b11;

  // Register reset values.
  localparam logic [COLOR_W-1:0] FG_RESET      = 4'hf;
  localparam logic [COLOR_W-1:0] BG_RESET      = 4'h0;
  localparam logic [SPACE_W-1:0] SPACING_RESET = 6'd1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_OFFSET,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decode;
    logic load_off;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_writes;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

// File: rtl/gcer_ctrl.sv
`timescale 1ns / 1ps

module gcer_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gcer_pkg::status_t status_i,
  output gcer_pkg::cmd_t    cmd_o
);
  import gcer_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = status_i.has_writes ? ST_OFFSET : ST_IDLE;
      end
      ST_OFFSET: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free && status_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
      end
      ST_OFFSET: begin
        cmd_o.load_off = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/gcer_dp.sv
`timescale 1ns / 1ps

module gcer_dp #(
  parameter int SCREEN_WIDTH   = gcer_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = gcer_pkg::SCREEN_HEIGHT_DEF,
  parameter int BYTES_PER_LINE = gcer_pkg::BYTES_PER_LINE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gcer_pkg::cmd_t                      cmd_i,
  output gcer_pkg::status_t                   status_o,
  input  logic                                cfg_valid_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [5:0]                          cfg_data_i,
  input  logic [1:0]                          op_i,
  input  logic [9:0]                          pos_x_i,
  input  logic [7:0]                          pos_y_i,
  input  logic [7:0]                          glyph_width_i,
  input  logic [7:0]                          glyph_height_i,
  input  logic [7:0]                          glyph_bits_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gcer_pkg::OFF_W-1:0]          write_offset_o,
  output logic [7:0]                          write_data_o,
  output logic [1:0]                          nibble_mask_o,
  output logic                                last_o
);
  import gcer_pkg::*;

  localparam int COL_W = $clog2(SCREEN_WIDTH + 320);
  localparam int ROW_W = 9;
  localparam int BPL_W = $clog2(BYTES_PER_LINE + 1);
  localparam int MUL_W = ROW_W + BPL_W;
  localparam int SUM_W = MUL_W + COL_W;

  // Configuration registers.
  logic [COLOR_W-1:0] fg_q, bg_q;
  logic [SPACE_W-1:0] spacing_q;

  // Captured input item.
  logic [1:0] op_q;
  logic [9:0] px_q;
  logic [7:0] py_q, gw_q, gh_q, bits_q;

  // Text and glyph state.
  logic             enabled_q, enabled_d;
  logic [COL_W-1:0] cursor_q, cursor_d;
  logic [COL_W-1:0] origin_q, origin_d;
  logic [7:0]       base_row_q, base_row_d;
  logic [7:0]       cur_row_q, cur_row_d;
  logic [COL_W-1:0] cur_pix_q, cur_pix_d;
  logic [7:0]       bits_left_q, bits_left_d;
  logic [15:0]      wh_q, wh_d;

  // Write generation registers.
  logic [MUL_W-1:0] row_mul_q;
  logic [COL_W-1:0] col_q, stop_q;
  logic [OFF_W-1:0] off_q;
  logic [7:0]       sh_q;
  logic [3:0]       gleft_q;

  // Output register.
  logic             out_valid_q;
  logic [OFF_W-1:0] out_off_q;
  logic [7:0]       out_data_q;
  logic [1:0]       out_mask_q;
  logic             out_last_q;

  // Decode signals.
  logic [3:0]       n_pix;
  logic [7:0]       new_bl;
  logic             row_end;
  logic [6:0]       npix;
  logic [COL_W:0]   end_col;
  logic [COL_W-1:0] stop_col;
  logic [ROW_W-1:0] row;
  logic             vis;
  logic             byte_go;
  logic             hdr_go;
  logic [7:0]       adv_w;
  logic [COL_W:0]   adv_sum;
  logic [8:0]       row_next;

  // Emit signals.
  logic             two;
  logic [COL_W:0]   next_col;
  logic [COLOR_W-1:0] color0, color1;
  logic [7:0]       wr_data;
  logic [1:0]       wr_mask;
  logic             emit_last;
  logic [SUM_W-1:0] off_sum;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q      <= FG_RESET;
      bg_q      <= BG_RESET;
      spacing_q <= SPACING_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FG:      fg_q      <= cfg_data_i[COLOR_W-1:0];
        REG_BG:      bg_q      <= cfg_data_i[COLOR_W-1:0];
        REG_SPACING: spacing_q <= cfg_data_i;
        default:     fg_q      <= fg_q;
      endcase
    end
  end

  // Input item capture on each transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      gw_q   <= glyph_width_i;
      gh_q   <= glyph_height_i;
      bits_q <= glyph_bits_i;
    end
  end

  // Pixel span of a bitmap byte and clipping.
  always_comb begin
    n_pix    = (bits_left_q < 8'd8) ? bits_left_q[3:0] : 4'd8;
    new_bl   = bits_left_q - {4'd0, n_pix};
    row_end  = (new_bl == 8'd0);
    npix     = {3'd0, n_pix} + (row_end ? {1'b0, spacing_q} : 7'd0);
    end_col  = {1'b0, cur_pix_q} + {{(COL_W-6){1'b0}}, npix};
    stop_col = (end_col < (COL_W+1)'(SCREEN_WIDTH)) ? end_col[COL_W-1:0]
                                                   : COL_W'(SCREEN_WIDTH);
    row      = {1'b0, base_row_q} + {1'b0, cur_row_q};
    vis      = (int'(row) < SCREEN_HEIGHT) && (int'(cur_pix_q) < SCREEN_WIDTH);
    byte_go  = (op_q == OP_BYTE) && enabled_q && (bits_left_q != 8'd0);
    hdr_go   = (op_q == OP_HEADER) && enabled_q;
    adv_w    = (op_q == OP_HEADER) ? gw_q : wh_q[7:0];
    adv_sum  = {1'b0, cursor_q} + {{(COL_W-7){1'b0}}, adv_w}
             + {{(COL_W-5){1'b0}}, spacing_q};
    row_next = {1'b0, cur_row_q} + 9'd1;
  end

  // Next state of the text and glyph state.
  always_comb begin
    enabled_d   = enabled_q;
    cursor_d    = cursor_q;
    origin_d    = origin_q;
    base_row_d  = base_row_q;
    cur_row_d   = cur_row_q;
    cur_pix_d   = cur_pix_q;
    bits_left_d = bits_left_q;
    wh_d        = wh_q;
    case (op_q)
      OP_BEGIN: begin
        cursor_d    = (int'(px_q) > SCREEN_WIDTH) ? COL_W'(SCREEN_WIDTH) : COL_W'(px_q);
        base_row_d  = py_q;
        enabled_d   = (int'(px_q) < SCREEN_WIDTH) && (int'(py_q) < SCREEN_HEIGHT);
        bits_left_d = 8'd0;
        cur_row_d   = 8'd0;
      end
      OP_HEADER: begin
        if (hdr_go) begin
          wh_d      = {gh_q, gw_q};
          cur_row_d = 8'd0;
          if ((gw_q == 8'd0) || (gh_q == 8'd0)) begin
            bits_left_d = 8'd0;
            if (adv_sum >= (COL_W+1)'(SCREEN_WIDTH)) begin
              cursor_d  = COL_W'(SCREEN_WIDTH);
              enabled_d = 1'b0;
            end else begin
              cursor_d = adv_sum[COL_W-1:0];
            end
          end else begin
            origin_d    = cursor_q;
            cur_pix_d   = cursor_q;
            bits_left_d = gw_q;
          end
        end
      end
      OP_BYTE: begin
        if (byte_go) begin
          bits_left_d = new_bl;
          cur_pix_d   = cur_pix_q + COL_W'(npix);
          if (row_end) begin
            if (row_next >= {1'b0, wh_q[15:8]}) begin
              cur_row_d = 8'd0;
              if (adv_sum >= (COL_W+1)'(SCREEN_WIDTH)) begin
                cursor_d  = COL_W'(SCREEN_WIDTH);
                enabled_d = 1'b0;
              end else begin
                cursor_d = adv_sum[COL_W-1:0];
              end
            end else begin
              cur_row_d   = row_next[7:0];
              bits_left_d = wh_q[7:0];
              cur_pix_d   = origin_q;
            end
          end
        end
      end
      default: begin
        enabled_d = enabled_q;
      end
    endcase
  end

  // Text and glyph state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      cursor_q    <= '0;
      origin_q    <= '0;
      base_row_q  <= '0;
      cur_row_q   <= '0;
      cur_pix_q   <= '0;
      bits_left_q <= '0;
      wh_q        <= '0;
    end else if (cmd_i.decode) begin
      enabled_q   <= enabled_d;
      cursor_q    <= cursor_d;
      origin_q    <= origin_d;
      base_row_q  <= base_row_d;
      cur_row_q   <= cur_row_d;
      cur_pix_q   <= cur_pix_d;
      bits_left_q <= bits_left_d;
      wh_q        <= wh_d;
    end
  end

  // Pixel pair for the current byte write.
  always_comb begin
    two      = !col_q[0] && (({1'b0, col_q} + 1'b1) < {1'b0, stop_q});
    next_col = {1'b0, col_q} + (two ? (COL_W+1)'(2) : (COL_W+1)'(1));
    color0   = ((gleft_q != 4'd0) && sh_q[7]) ? fg_q : bg_q;
    color1   = ((gleft_q > 4'd1) && sh_q[6]) ? fg_q : bg_q;
    if (col_q[0]) begin
      wr_data = {4'h0, color0};
      wr_mask = MASK_LO;
    end else if (two) begin
      wr_data = {color0, color1};
      wr_mask = MASK_BOTH;
    end else begin
      wr_data = {color0, 4'h0};
      wr_mask = MASK_HI;
    end
    emit_last = (next_col >= {1'b0, stop_q});
    off_sum   = {{COL_W{1'b0}}, row_mul_q} + {{(MUL_W+1){1'b0}}, col_q[COL_W-1:1]};
  end

  // Write generation: span setup, row multiply, offset and column walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      row_mul_q <= MUL_W'(row) * MUL_W'(BYTES_PER_LINE);
      col_q     <= cur_pix_q;
      stop_q    <= stop_col;
      sh_q      <= bits_q;
      gleft_q   <= n_pix;
    end else if (cmd_i.load_off) begin
      off_q <= off_sum[OFF_W-1:0];
    end else if (cmd_i.emit) begin
      col_q   <= next_col[COL_W-1:0];
      off_q   <= off_q + 1'b1;
      sh_q    <= two ? {sh_q[5:0], 2'b00} : {sh_q[6:0], 1'b0};
      if (gleft_q > 4'd1) begin
        gleft_q <= gleft_q - (two ? 4'd2 : 4'd1);
      end else begin
        gleft_q <= 4'd0;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_off_q  <= off_q;
      out_data_q <= wr_data;
      out_mask_q <= wr_mask;
      out_last_q <= emit_last;
    end
  end

  assign status_o.has_writes = byte_go && vis;
  assign status_o.emit_last  = emit_last;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign write_offset_o = out_off_q;
  assign write_data_o   = out_data_q;
  assign nibble_mask_o  = out_mask_q;
  assign last_o         = out_last_q;

  // A write that is not the last of its item ends on a byte boundary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !emit_last |=> !col_q[0])
    else $error("column not byte aligned after a non-final write");

  // An enabled text run always has its cursor on screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    enabled_q |-> (int'(cursor_q) < SCREEN_WIDTH))
    else $error("cursor off screen while drawing is enabled");

  // A glyph in progress implies drawing is enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bits_left_q != 8'd0) |-> enabled_q)
    else $error("glyph in progress while drawing is disabled");

  // Every presented write carries at least one nibble.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_mask_q != 2'b00))
    else $error("write with empty nibble mask");

endmodule

// File: rtl/glyph_color_expansion_renderer_top.sv
`timescale 1ns / 1ps

// An item is accepted, then decoded, then its offset is set up; the byte writes of a bitmap
// byte then enter the output register at one write per cycle while the output does not stall.
// An item that causes no write returns to idle after decode. A new item is accepted only
// once the current one is through emission.
// Reset (rst_ni, asynchronous, active low) sets colors 15 and 0, spacing 1, drawing off.
module glyph_color_expansion_renderer_top #(
  parameter int SCREEN_WIDTH   = gcer_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = gcer_pkg::SCREEN_HEIGHT_DEF,
  parameter int BYTES_PER_LINE = gcer_pkg::BYTES_PER_LINE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [5:0]                 cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic [9:0]                 pos_x_i,
  input  logic [7:0]                 pos_y_i,
  input  logic [7:0]                 glyph_width_i,
  input  logic [7:0]                 glyph_height_i,
  input  logic [7:0]                 glyph_bits_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gcer_pkg::OFF_W-1:0] write_offset_o,
  output logic [7:0]                 write_data_o,
  output logic [1:0]                 nibble_mask_o,
  output logic                       last_o
);
  import gcer_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  // Sequencer for decode, offset setup and write emission.
  gcer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Glyph state, pixel packing and output register.
  gcer_dp #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .BYTES_PER_LINE (BYTES_PER_LINE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .glyph_width_i  (glyph_width_i),
    .glyph_height_i (glyph_height_i),
    .glyph_bits_i   (glyph_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_offset_o (write_offset_o),
    .write_data_o   (write_data_o),
    .nibble_mask_o  (nibble_mask_o),
    .last_o         (last_o)
  );

endmodule

// File: sim/glyph_color_expansion_renderer_top_test.sv
`timescale 1ns / 1ps

module glyph_color_expansion_renderer_top_test;
  import gcer_pkg::*;

  localparam int SCREEN_W    = SCREEN_WIDTH_DEF;
  localparam int SCREEN_H    = SCREEN_HEIGHT_DEF;
  localparam int LINE_BYTES  = BYTES_PER_LINE_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One nibble-masked frame buffer write.
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [7:0]       data;
    logic [1:0]       mask;
    logic             last;
  } fb_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = REG_FG;
  logic [5:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = OP_BEGIN;
  logic [9:0] pos_x_i = '0;
  logic [7:0] pos_y_i = '0;
  logic [7:0] glyph_width_i = '0;
  logic [7:0] glyph_height_i = '0;
  logic [7:0] glyph_bits_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [OFF_W-1:0] write_offset_o;
  logic [7:0] write_data_o;
  logic [1:0] nibble_mask_o;
  logic last_o;

  glyph_color_expansion_renderer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .glyph_width_i  (glyph_width_i),
    .glyph_height_i (glyph_height_i),
    .glyph_bits_i   (glyph_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_offset_o (write_offset_o),
    .write_data_o   (write_data_o),
    .nibble_mask_o  (nibble_mask_o),
    .last_o         (last_o)
  );

  // Writes the renderer is expected to produce, oldest first.
  fb_write_t expected_writes[$];
  int mismatches = 0;
  int drawn_items = 0;

  // Idle percentages for the sender and the receiver, and a long receiver hold-off.
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int ready_hold_cycles = 0;

  // Mirror of the renderer's registers and text state.
  logic [3:0] fg_color = FG_RESET;
  logic [3:0] bg_color = BG_RESET;
  logic [5:0] spacing = SPACING_RESET;
  bit pen_on = 1'b0;
  int pen_col = 0;
  int glyph_left_col = 0;
  int text_row = 0;
  int glyph_row = 0;
  int pix_col = 0;
  int bits_left = 0;
  int glyph_w = 0;
  int glyph_h = 0;

  // Pixels of the same byte are merged before the write is queued.
  bit merge_valid = 1'b0;
  fb_write_t merge_buf;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void flush_merge();
    if (merge_valid) begin
      expected_writes.push_back(merge_buf);
      merge_valid = 1'b0;
    end
  endfunction

  // Place one pixel, dropping it when it falls off the screen.
  function automatic void plot(int col, int row, logic [3:0] color);
    fb_write_t px_write;
    if (col >= SCREEN_W || row >= SCREEN_H) return;
    px_write.offset = row * LINE_BYTES + col / 2;
    px_write.last = 1'b0;
    if (col % 2 == 1) begin
      px_write.data = {4'h0, color};
      px_write.mask = MASK_LO;
    end else begin
      px_write.data = {color, 4'h0};
      px_write.mask = MASK_HI;
    end
    if (merge_valid && merge_buf.offset == px_write.offset) begin
      merge_buf.data = merge_buf.data | px_write.data;
      merge_buf.mask = merge_buf.mask | px_write.mask;
    end else begin
      flush_merge();
      merge_buf = px_write;
      merge_valid = 1'b1;
    end
  endfunction

  // Moving the cursor to the right edge turns drawing off.
  function automatic void bump_cursor(int amount);
    pen_col = pen_col + amount;
    if (pen_col >= SCREEN_W) begin
      pen_col = SCREEN_W;
      pen_on = 1'b0;
    end
  endfunction

  // Work out the writes one transfer causes; returns 1 when the item was not ignored.
  function automatic bit predict_item(logic [1:0] op, logic [9:0] px, logic [7:0] py,
                                      logic [7:0] gw, logic [7:0] gh, logic [7:0] bits);
    int row;
    int n;
    int i;
    bit acted;
    acted = 1'b0;
    merge_valid = 1'b0;
    case (op)
      OP_BEGIN: begin
        pen_col = px;
        text_row = py;
        pen_on = (px < SCREEN_W) && (py < SCREEN_H);
        if (!pen_on && pen_col > SCREEN_W) pen_col = SCREEN_W;
        bits_left = 0;
        glyph_row = 0;
        acted = 1'b1;
      end
      OP_HEADER: begin
        if (pen_on) begin
          glyph_w = gw;
          glyph_h = gh;
          glyph_row = 0;
          if (gw == 0 || gh == 0) begin
            bits_left = 0;
            bump_cursor(glyph_w + spacing);
          end else begin
            glyph_left_col = pen_col;
            pix_col = pen_col;
            bits_left = glyph_w;
          end
          acted = 1'b1;
        end
      end
      OP_BYTE: begin
        if (pen_on && bits_left != 0) begin
          row = text_row + glyph_row;
          n = (bits_left < 8) ? bits_left : 8;
          for (i = 0; i < n; i++) begin
            plot(pix_col, row, bits[7 - i] ? fg_color : bg_color);
            pix_col++;
          end
          bits_left = bits_left - n;
          // End of a glyph row: spacing, then the next row or the next glyph.
          if (bits_left == 0) begin
            for (i = 0; i < spacing; i++) begin
              plot(pix_col, row, bg_color);
              pix_col++;
            end
            glyph_row++;
            if (glyph_row >= glyph_h) begin
              glyph_row = 0;
              bump_cursor(glyph_w + spacing);
            end else begin
              bits_left = glyph_w;
              pix_col = glyph_left_col;
            end
          end
          acted = 1'b1;
        end
      end
      default: ;
    endcase
    // The write still held in the merge buffer is the final one of this item.
    if (merge_valid) merge_buf.last = 1'b1;
    flush_merge();
    return acted;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every accepted write with the oldest expected one.
  always @(posedge clk_i) begin
    fb_write_t got;
    fb_write_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {write_offset_o, write_data_o, nibble_mask_o, last_o};
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, actual offset 0x%0h data 0x%0h mask %0b",
                 $time, got.offset, got.data, got.mask);
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        check_field("write_offset", want.offset, got.offset);
        check_field("write_data", want.data, got.data);
        check_field("nibble_mask", want.mask, got.mask);
        check_field("last", want.last, got.last);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when a test requests one.
  always @(posedge clk_i) begin
    if (ready_hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      ready_hold_cycles <= ready_hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one item and wait for its transfer, with a random gap in front of it.
  task automatic send_item(input logic [1:0] op, input logic [9:0] px, input logic [7:0] py,
                           input logic [7:0] gw, input logic [7:0] gh, input logic [7:0] bits);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    pos_x_i <= px;
    pos_y_i <= py;
    glyph_width_i <= gw;
    glyph_height_i <= gh;
    glyph_bits_i <= bits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_item(op, px, py, gw, gh, bits)) drawn_items++;
  endtask

  task automatic begin_text(input int px, input int py);
    send_item(OP_BEGIN, px, py, $urandom, $urandom, $urandom);
  endtask

  task automatic glyph_header(input int w, input int h);
    send_item(OP_HEADER, $urandom, $urandom, w, h, $urandom);
  endtask

  task automatic glyph_byte(input logic [7:0] bits);
    send_item(OP_BYTE, $urandom, $urandom, $urandom, $urandom, bits);
  endtask

  // Stop offering items and wait until every expected write has arrived.
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_transfer(input logic [1:0] idx, input logic [5:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Write all three registers; only called while the renderer is idle.
  task automatic write_config(input logic [5:0] fg, input logic [5:0] bg,
                              input logic [5:0] sp);
    cfg_transfer(REG_FG, fg);
    cfg_transfer(REG_BG, bg);
    cfg_transfer(REG_SPACING, sp);
    cfg_valid_i <= 1'b0;
    fg_color = fg[3:0];
    bg_color = bg[3:0];
    spacing = sp;
    @(posedge clk_i);
  endtask

  // Glyph drawing at reset colors, ignored items, zero-size glyphs and dropped glyphs.
  task automatic test_glyph_basics();
    glyph_byte(8'hff);
    send_item(OP_UNUSED, 10'h3ff, 8'hff, 8'hff, 8'hff, 8'hff);
    begin_text(0, 0);
    glyph_header(8, 2);
    glyph_byte(8'ha5);
    glyph_byte(8'h5a);
    glyph_byte(8'hff);
    glyph_header(0, 255);
    glyph_header(255, 0);
    glyph_header(10, 2);
    glyph_byte(8'hff);
    glyph_header(3, 1);
    glyph_byte(8'hbf);
    wait_for_idle();
  endtask

  // Clipping at the right and bottom edges and starts off the screen.
  task automatic test_clipping();
    begin_text(318, 191);
    glyph_header(5, 2);
    glyph_byte(8'hf8);
    glyph_byte(8'h08);
    glyph_byte(8'hff);
    glyph_header(1, 1);
    begin_text(1023, 255);
    begin_text(0, 192);
    begin_text(319, 0);
    glyph_header(1, 1);
    glyph_byte(8'h80);
    wait_for_idle();
  endtask

  // Register extremes: widest spacing, then no spacing with an odd start column.
  task automatic test_config_extremes();
    write_config(6'h30, 6'h3f, 6'd63);
    begin_text(1, 100);
    glyph_header(8, 1);
    glyph_byte(8'h81);
    wait_for_idle();
    write_config(6'h0f, 6'h00, 6'd0);
    begin_text(1, 0);
    glyph_header(3, 2);
    glyph_byte(8'ha0);
    glyph_byte(8'h40);
    wait_for_idle();
  endtask

  // One line of text with random glyphs, sometimes cut short, or a single noise item.
  task automatic random_text_run();
    int glyphs;
    int w;
    int h;
    int nbytes;
    int b;
    if ($urandom_range(99) < 15) begin
      send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      return;
    end
    if ($urandom_range(9) == 0) begin_text($urandom_range(1023), $urandom_range(255));
    else begin_text($urandom_range(SCREEN_W - 1), $urandom_range(SCREEN_H - 1));
    glyphs = $urandom_range(4, 1);
    repeat (glyphs) begin
      if ($urandom_range(19) == 0) begin
        // Zero-size glyph.
        if ($urandom_range(1) == 0) begin
          w = 0;
          h = $urandom_range(255);
        end else begin
          w = $urandom_range(255);
          h = 0;
        end
      end else if ($urandom_range(9) == 0) begin
        w = $urandom_range(255, 17);
        h = 1;
      end else begin
        w = $urandom_range(16, 1);
        h = $urandom_range(4, 1);
      end
      glyph_header(w, h);
      nbytes = (w == 0 || h == 0) ? 0 : ((w + 7) / 8) * h;
      b = 0;
      while (b < nbytes && $urandom_range(99) >= 3) begin
        glyph_byte($urandom);
        b++;
      end
    end
  endtask

  // Random text under each idling pattern, with new register values per phase.
  task automatic test_random_phases();
    int phase;
    int goal;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 54; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 54; end
        default: begin sender_idle_pct = 21; stall_pct = 21; end
      endcase
      write_config($urandom_range(63), $urandom_range(63),
                   ($urandom_range(5) == 0) ? 6'd63 : 6'($urandom_range(3)));
      goal = drawn_items + 36;
      while (drawn_items < goal) random_text_run();
      wait_for_idle();
    end
  endtask

  // The receiver holds off long enough for the renderer to stall its input.
  task automatic test_back_pressure();
    int n;
    sender_idle_pct = 0;
    stall_pct = 0;
    write_config(6'd9, 6'd6, 6'd2);
    ready_hold_cycles = 300;
    begin_text(10, 50);
    glyph_header(16, 4);
    for (n = 0; n < 8; n++) glyph_byte($urandom);
    wait_for_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_glyph_basics();
    test_clipping();
    test_config_extremes();
    test_random_phases();
    test_back_pressure();
    wait_for_idle();
    if (expected_writes.size() != 0) begin
      $display("%0t: write to offset 0x%0h never arrived, expected data 0x%0h, actual none",
               $time, expected_writes[0].offset, expected_writes[0].data);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: glyph_color_expansion_renderer_top.f
rtl/gcer_pkg.sv
rtl/gcer_ctrl.sv
rtl/gcer_dp.sv
rtl/glyph_color_expansion_renderer_top.sv
sim/glyph_color_expansion_renderer_top_test.sv
